>>> rtl/fonc_pkg.sv
// Shared types, constants and the microcode program of the frequency-to-note block.
package fonc_pkg;

	// field widths
	localparam int FREQ_W  = 24;
	localparam int A4_W    = 18;
	localparam int OCT_W   = 4;
	localparam int SEMI_W  = 4;
	localparam int CENTS_W = 7;

	// default fixed-point formats
	localparam int DEF_FREQ_FRAC_BITS = 8;
	localparam int DEF_WORK_FRAC_BITS = 16;

	// reset reference pitch: 440 Hz in Q10.8
	localparam logic [A4_W-1:0] A4_RESET = 18'd112640;

	// Q1.30 constants and multiplier geometry
	localparam int K_FRAC  = 30;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 31;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SPLIT_W = 2 * MUL_A_W;
	localparam logic [MUL_B_W-1:0] K_C0_Q30   = 31'd39903169;
	localparam logic [MUL_B_W-1:0] K_SEMI_Q30 = 31'd1137589835;
	localparam logic [MUL_B_W-1:0] K_CENT_Q30 = 31'd1074362220;

	// search limits and rounding
	localparam logic [OCT_W-1:0]   MAX_DOUBLINGS  = 4'd15;
	localparam logic [SEMI_W-1:0]  MAX_SEMITONES  = 4'd11;
	localparam logic [CENTS_W-1:0] MAX_CENTS      = 7'd99;
	localparam logic [CENTS_W-1:0] ROUND_LIMIT    = 7'd50;
	localparam logic [CENTS_W-1:0] CENTS_PER_NOTE = 7'd100;
	localparam logic [SEMI_W-1:0]  NOTES_PER_OCT  = 4'd12;

	// step counter
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
	localparam logic [PC_W-1:0] PC_DOUBLE  = 4'd4;
	localparam logic [PC_W-1:0] PC_SEMI_HI = 4'd6;
	localparam logic [PC_W-1:0] PC_CENT_HI = 4'd9;
	localparam logic [PC_W-1:0] PC_ROUND   = 4'd11;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_MUL_C0,
		OP_LOAD_C0,
		OP_CHECK,
		OP_DOUBLE,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_TEST,
		OP_ROUND,
		OP_RESTART
	} op_t;

	typedef enum logic {
		KS_SEMI,
		KS_CENT
	} k_sel_t;

	typedef struct packed {
		op_t             op;
		k_sel_t          ksel;
		logic [PC_W-1:0] jmp;
	} ctrl_word_t;

	typedef struct packed {
		logic start;
		logic le_test;
		logic le_double;
		logic le_next;
		logic dbl_room;
		logic step_room;
	} status_t;

	// microcode program: a taken condition jumps to jmp, otherwise advance
	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
		ctrl_word_t w;
		w = '{op: OP_RESTART, ksel: KS_SEMI, jmp: PC_IDLE};
		unique case (addr)
			4'd0:    w = '{op: OP_WAIT,    ksel: KS_SEMI, jmp: PC_IDLE};
			4'd1:    w = '{op: OP_MUL_C0,  ksel: KS_SEMI, jmp: PC_IDLE};
			4'd2:    w = '{op: OP_LOAD_C0, ksel: KS_SEMI, jmp: PC_IDLE};
			4'd3:    w = '{op: OP_CHECK,   ksel: KS_SEMI, jmp: PC_ROUND};
			4'd4:    w = '{op: OP_DOUBLE,  ksel: KS_SEMI, jmp: PC_DOUBLE};
			4'd5:    w = '{op: OP_MUL_LO,  ksel: KS_SEMI, jmp: PC_IDLE};
			4'd6:    w = '{op: OP_MUL_HI,  ksel: KS_SEMI, jmp: PC_IDLE};
			4'd7:    w = '{op: OP_TEST,    ksel: KS_SEMI, jmp: PC_SEMI_HI};
			4'd8:    w = '{op: OP_MUL_LO,  ksel: KS_CENT, jmp: PC_IDLE};
			4'd9:    w = '{op: OP_MUL_HI,  ksel: KS_CENT, jmp: PC_IDLE};
			4'd10:   w = '{op: OP_TEST,    ksel: KS_CENT, jmp: PC_CENT_HI};
			4'd11:   w = '{op: OP_ROUND,   ksel: KS_SEMI, jmp: PC_IDLE};
			default: w = '{op: OP_RESTART, ksel: KS_SEMI, jmp: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/frequency_to_octave_note_cents.sv
// Top level: frequency to equal-tempered octave, semitone and cents.
//
// Usage: drive frequency (unsigned, FREQ_FRAC_BITS fraction bits) and raise
// start; the item is taken at a clock edge where start is high and busy is
// low. busy stays high while the search runs. The result appears on octave,
// semitone and cents_offset for one cycle with done high; the receiver has
// no way to hold it, so it must take it in that cycle.
// The A4 reference is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while no item is in flight.
// Steps: one shared 30x31 multiplier does every product. After the C0
// product and load, the search doubles the test value once per octave,
// then steps by semitones and then by cents: each semitone or cent step
// is a multiply-high/add step and a compare step that also starts the
// next low-half product. A frequency below C0 goes straight to rounding.
// A new item can be taken in the cycle done is high.
// Reset: the step counter returns to idle, done drops and the reference
// goes back to 440 Hz.
module frequency_to_octave_note_cents #(
	parameter int FREQ_FRAC_BITS = fonc_pkg::DEF_FREQ_FRAC_BITS,
	parameter int WORK_FRAC_BITS = fonc_pkg::DEF_WORK_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [fonc_pkg::FREQ_W-1:0]        frequency,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fonc_pkg::A4_W-1:0]          cfg_data,
	output logic                               done,
	output logic [fonc_pkg::OCT_W-1:0]         octave,
	output logic [fonc_pkg::SEMI_W-1:0]        semitone,
	output logic signed [fonc_pkg::CENTS_W-1:0] cents_offset
);
	import fonc_pkg::*;

	// test value width holds twice the largest aligned input
	localparam int TW       = FREQ_W + WORK_FRAC_BITS - FREQ_FRAC_BITS + 1;
	localparam int CW       = TW + FREQ_FRAC_BITS;
	localparam int SHIFT_C0 = K_FRAC + FREQ_FRAC_BITS - WORK_FRAC_BITS;

	ctrl_word_t         cw;
	status_t            status;
	logic [PC_W-1:0]    pc;

	logic [A4_W-1:0]    a4_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [TW-1:0]      t_q;
	logic [TW-1:0]      n_q;
	logic [PROD_W-1:0]  pl_q;
	logic [OCT_W-1:0]   oct_q;
	logic [SEMI_W-1:0]  note_q;
	logic [CENTS_W-1:0] cents_q;
	logic               done_q;
	logic [OCT_W-1:0]   oct_out_q;
	logic [SEMI_W-1:0]  semi_out_q;
	logic [CENTS_W-1:0] cents_out_q;

	logic [SPLIT_W-1:0] t_x;
	logic [SPLIT_W-1:0] n_x;
	logic [TW-1:0]      t_dbl;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [MUL_B_W-1:0] k_step;

	logic [OCT_W-1:0]   oct_rnd;
	logic [SEMI_W-1:0]  semi_rnd;
	logic [CENTS_W-1:0] cents_rnd;
	logic [SEMI_W-1:0]  semi_inc;

	// test value against the input, both aligned to the same fraction bits
	function automatic logic at_or_below(input logic [TW-1:0] v,
		input logic [FREQ_W-1:0] f);
		logic [CW-1:0] lhs;
		logic [CW-1:0] rhs;
		lhs = CW'(v) << FREQ_FRAC_BITS;
		rhs = CW'(f) << WORK_FRAC_BITS;
		return lhs <= rhs;
	endfunction

	fonc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw),
		.pc     (pc)
	);

	// select multiplier operands for this step
	always_comb begin
		t_x    = SPLIT_W'(t_q);
		n_x    = SPLIT_W'(n_q);
		t_dbl  = {t_q[TW-2:0], 1'b0};
		k_step = (cw.ksel == KS_CENT) ? K_CENT_Q30 : K_SEMI_Q30;
		mul_a  = '0;
		mul_b  = '0;
		case (cw.op)
			OP_MUL_C0: begin
				mul_a = MUL_A_W'(a4_q);
				mul_b = K_C0_Q30;
			end
			OP_MUL_LO: begin
				mul_a = t_x[MUL_A_W-1:0];
				mul_b = k_step;
			end
			OP_MUL_HI: begin
				mul_a = t_x[SPLIT_W-1:MUL_A_W];
				mul_b = k_step;
			end
			OP_TEST: begin
				mul_a = n_x[MUL_A_W-1:0];
				mul_b = k_step;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// gather the sequencer's branch conditions
	always_comb begin
		status.start     = start;
		status.le_test   = at_or_below(t_q, freq_q);
		status.le_double = at_or_below(t_dbl, freq_q);
		status.le_next   = at_or_below(n_q, freq_q);
		status.dbl_room  = oct_q < MAX_DOUBLINGS;
		status.step_room = (cw.ksel == KS_CENT) ? (cents_q < MAX_CENTS)
			: (note_q < MAX_SEMITONES);
	end

	// round a cents count above the half note up to the next note
	always_comb begin
		oct_rnd   = oct_q;
		semi_rnd  = note_q;
		cents_rnd = cents_q;
		semi_inc  = note_q + 1'b1;
		if (cents_q > ROUND_LIMIT) begin
			cents_rnd = cents_q - CENTS_PER_NOTE;
			if (semi_inc >= NOTES_PER_OCT) begin
				semi_rnd = '0;
				oct_rnd  = oct_q + 1'b1;
			end else begin
				semi_rnd = semi_inc;
			end
		end
	end

	// hold the reference pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a4_q <= A4_RESET;
		end else if (cfg_valid) begin
			a4_q <= cfg_data;
		end
	end

	// pulse the result strobe after the rounding step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cw.op == OP_ROUND);
		end
	end

	// datapath registers driven by the control word
	always_ff @(posedge clk) begin
		case (cw.op) inside
			OP_WAIT: begin
				if (start) begin
					freq_q  <= frequency;
					oct_q   <= '0;
					note_q  <= '0;
					cents_q <= '0;
				end
			end
			OP_MUL_C0, OP_MUL_LO: begin
				pl_q <= prod;
			end
			OP_LOAD_C0: begin
				t_q <= TW'(pl_q >> SHIFT_C0);
			end
			OP_DOUBLE: begin
				if (status.le_double && status.dbl_room) begin
					t_q   <= t_dbl;
					oct_q <= oct_q + 1'b1;
				end
			end
			OP_MUL_HI: begin
				n_q <= TW'(prod + PROD_W'(pl_q >> K_FRAC));
			end
			OP_TEST: begin
				pl_q <= prod;
				if (status.le_next && status.step_room) begin
					t_q <= n_q;
					if (cw.ksel == KS_CENT) begin
						cents_q <= cents_q + 1'b1;
					end else begin
						note_q <= note_q + 1'b1;
					end
				end
			end
			OP_ROUND: begin
				oct_out_q   <= oct_rnd;
				semi_out_q  <= semi_rnd;
				cents_out_q <= cents_rnd;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (pc != PC_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign octave       = oct_out_q;
	assign semitone     = semi_out_q;
	assign cents_offset = cents_out_q;

endmodule

>>> rtl/fonc_ctrl.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module fonc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fonc_pkg::status_t     status,
	output fonc_pkg::ctrl_word_t  cw,
	output logic [fonc_pkg::PC_W-1:0] pc
);
	import fonc_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic            take;

	// hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// fetch the control word and pick the next step
	always_comb begin
		cw = ucode_rom(pc_q);
		take = 1'b0;
		unique case (cw.op)
			OP_WAIT:    take = !status.start;
			OP_CHECK:   take = !status.le_test;
			OP_DOUBLE:  take = status.le_double && status.dbl_room;
			OP_TEST:    take = status.le_next && status.step_room;
			OP_ROUND:   take = 1'b1;
			OP_RESTART: take = 1'b1;
			default:    take = 1'b0;
		endcase
		pc_next = take ? cw.jmp : pc_q + 1'b1;
	end

	assign pc = pc_q;

endmodule

>>> tb/frequency_to_octave_note_cents_tb.sv
// Testbench for the frequency-to-note block: directed and random frequencies checked against a predictor.
`timescale 1ns / 100ps

module frequency_to_octave_note_cents_tb;
	import fonc_pkg::*;

	localparam int C0_SHIFT     = K_FRAC + DEF_FREQ_FRAC_BITS - DEF_WORK_FRAC_BITS;
	localparam int DRAIN_CYCLES = 300;
	localparam int END_LIMIT    = 2000;

	typedef struct {
		logic [OCT_W-1:0]          octave;
		logic [SEMI_W-1:0]         semitone;
		logic signed [CENTS_W-1:0] cents;
	} note_t;

	// Pitch predictor and queue of notes still owed by the block
	class pitch_scoreboard;
		logic [A4_W-1:0] a4;
		note_t           expected_notes[$];
		int              errors;

		function new();
			a4 = A4_RESET;
			errors = 0;
		endfunction

		// Multiply by a Q1.30 constant, truncating the product
		function logic [63:0] scale_q30(logic [63:0] t, logic [63:0] k);
			logic [63:0] lo;
			lo = t & 64'h3FFF_FFFF;
			return (t >> K_FRAC) * k + ((lo * k) >> K_FRAC);
		endfunction

		function logic [63:0] c0_value();
			logic [63:0] ref_wide;
			ref_wide = {46'd0, a4};
			return (ref_wide * 64'(K_C0_Q30)) >> C0_SHIFT;
		endfunction

		// Lowest frequency (Q16.8) that reaches the given octave, semitone and cent
		function logic [63:0] note_to_frequency(int oct, int semi, int cent);
			logic [63:0] t;
			t = c0_value() << oct;
			repeat (semi) t = scale_q30(t, 64'(K_SEMI_Q30));
			repeat (cent) t = scale_q30(t, 64'(K_CENT_Q30));
			return (t + 255) >> DEF_FREQ_FRAC_BITS;
		endfunction

		// Walk the scale for an accepted frequency and queue the note it gives
		function void note_frequency(logic [FREQ_W-1:0] freq);
			logic [63:0] t, nxt, target;
			int          oct, semi, cent;
			note_t       n;
			target = {40'd0, freq} << DEF_WORK_FRAC_BITS;
			t = c0_value();
			oct = 0;
			semi = 0;
			cent = 0;
			n = '{octave: '0, semitone: '0, cents: '0};
			if ((t << DEF_FREQ_FRAC_BITS) <= target) begin
				while (oct < MAX_DOUBLINGS && ((t << (DEF_FREQ_FRAC_BITS + 1)) <= target)) begin
					t = t << 1;
					oct++;
				end
				while (semi < MAX_SEMITONES) begin
					nxt = scale_q30(t, 64'(K_SEMI_Q30));
					if ((nxt << DEF_FREQ_FRAC_BITS) > target)
						break;
					t = nxt;
					semi++;
				end
				while (cent < MAX_CENTS) begin
					nxt = scale_q30(t, 64'(K_CENT_Q30));
					if ((nxt << DEF_FREQ_FRAC_BITS) > target)
						break;
					t = nxt;
					cent++;
				end
				// round up to the next note, carrying into the octave
				if (cent > ROUND_LIMIT) begin
					cent -= int'(CENTS_PER_NOTE);
					semi++;
					if (semi >= NOTES_PER_OCT) begin
						semi = 0;
						oct++;
					end
				end
				n.octave = oct[OCT_W-1:0];
				n.semitone = semi[SEMI_W-1:0];
				n.cents = cent[CENTS_W-1:0];
			end
			expected_notes.push_back(n);
		endfunction

		function void check_note(logic [OCT_W-1:0] oct, logic [SEMI_W-1:0] semi,
				logic signed [CENTS_W-1:0] cents);
			note_t n;
			if (expected_notes.size() == 0) begin
				$display("%0t: unexpected result oct %0d semitone %0d cents %0d",
					$time, oct, semi, cents);
				errors++;
				return;
			end
			n = expected_notes.pop_front();
			if (oct !== n.octave) begin
				$display("%0t: octave expected %0d, got %0d", $time, n.octave, oct);
				errors++;
			end
			if (semi !== n.semitone) begin
				$display("%0t: semitone expected %0d, got %0d", $time, n.semitone, semi);
				errors++;
			end
			if (cents !== n.cents) begin
				$display("%0t: cents_offset expected %0d, got %0d", $time, n.cents, cents);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [FREQ_W-1:0]         frequency;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [A4_W-1:0]           cfg_data;
	logic                      done;
	logic [OCT_W-1:0]          octave;
	logic [SEMI_W-1:0]         semitone;
	logic signed [CENTS_W-1:0] cents_offset;

	pitch_scoreboard sb;
	bit              idle_on;

	frequency_to_octave_note_cents dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.frequency    (frequency),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.octave       (octave),
		.semitone     (semitone),
		.cents_offset (cents_offset)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predict on every accepted item, check on every strobe
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_frequency(frequency);
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_note(octave, semitone, cents_offset);
	end

	// Hold one item on the port until taken, dropping start at random meanwhile
	task automatic send(logic [FREQ_W-1:0] freq);
		frequency <= freq;
		forever begin
			start <= !(idle_on && $urandom_range(99) < 14);
			@(posedge clk);
			if (start && !busy)
				break;
		end
	endtask

	// Hold off the sender until every owed note has come back
	task automatic drain();
		start <= 1'b0;
		// let the last accepted item reach the predictor first
		@(posedge clk);
		while (sb.expected_notes.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_a4(logic [A4_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.a4 = value;
	endtask

	// Mix of uniform, log-spread and near-note frequencies
	function automatic logic [FREQ_W-1:0] random_frequency();
		logic [63:0] f;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			f = 64'($urandom & 32'hFF_FFFF);
		end else if (pick < 50) begin
			f = 64'($urandom) & ((64'd1 << $urandom_range(24, 1)) - 1);
		end else begin
			if (pick < 90)
				f = sb.note_to_frequency($urandom_range(15), $urandom_range(11),
					$urandom_range(99));
			else
				f = sb.note_to_frequency(0, 0, 0);
			f = f + 64'($urandom_range(4));
			f = (f >= 2) ? f - 2 : 64'd0;
			if (f > 64'hFF_FFFF)
				f = 64'($urandom & 32'hFF_FFFF);
		end
		return f[FREQ_W-1:0];
	endfunction

	task automatic random_items(int count);
		repeat (count) send(random_frequency());
	endtask

	initial begin
		int          wait_cycles;
		logic [63:0] c0_freq;
		sb = new();
		idle_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		frequency = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, the C0 edge and rounding edges at the reset reference
		c0_freq = sb.note_to_frequency(0, 0, 0);
		send(24'd0);
		send(24'd1);
		send(24'hFF_FFFF);
		send(24'h80_0000);
		send(24'h7F_FFFF);
		send(FREQ_W'(c0_freq - 1));
		send(FREQ_W'(c0_freq));
		send(24'd112640);
		send(24'd112639);
		send(24'd56320);
		send(FREQ_W'(sb.note_to_frequency(4, 9, 50)));
		send(FREQ_W'(sb.note_to_frequency(4, 9, 51)));
		send(FREQ_W'(sb.note_to_frequency(4, 11, 50)));
		send(FREQ_W'(sb.note_to_frequency(4, 11, 51)));
		random_items(300);

		// Highest reference, with no idling at all
		write_a4(18'd256000);
		idle_on = 1'b0;
		random_items(250);
		idle_on = 1'b1;

		write_a4(18'd25600);
		random_items(250);

		// Tiny reference: doubling bound and octave wrap
		write_a4(18'd1);
		send(24'hFF_FFFF);
		send(24'd0);
		send(24'd1);
		send(24'h00_0100);
		random_items(60);

		// Zero reference makes C0 zero
		write_a4(18'd0);
		send(24'd0);
		send(24'hFF_FFFF);
		random_items(20);

		repeat (3) begin
			write_a4(A4_W'($urandom_range(256000, 25600)));
			random_items(200);
		end

		write_a4(A4_RESET);
		random_items(150);

		// Wait for the last notes, then watch for strays
		start <= 1'b0;
		wait_cycles = 0;
		while (sb.expected_notes.size() != 0 && wait_cycles < END_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_notes.size() != 0)
			$display("%0t: %0d results never arrived", $time, sb.expected_notes.size());
		if (sb.errors == 0 && sb.expected_notes.size() == 0)
			$display("PASS frequency_to_octave_note_cents");
		else
			$display("FAIL frequency_to_octave_note_cents");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("FAIL frequency_to_octave_note_cents");
		$finish;
	end

endmodule
